// ===== rtl/core/wed_pkg.sv =====
// Package for the wildcard edit distance block: payload structs, the token
// that travels along the cell chain, register codes and small cost helpers.
// No dependencies.
package wed_pkg;

    localparam int COST_W       = 5;
    localparam int CNT_W        = 6;
    localparam int CHAR_W       = 8;
    localparam int LEN_W        = 5;
    localparam int CFG_W        = 64;
    localparam int CFG_IDX_W    = 2;
    localparam int MIN_PATTERN  = 3;

    localparam logic [CHAR_W-1:0] WILDCARD     = 8'h3F;
    localparam logic [COST_W-1:0] COST_CEILING = 5'd31;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT_LO     = 2'd0,
        REG_PAT_HI     = 2'd1,
        REG_PAT_LEN    = 2'd2,
        REG_DIST_LIMIT = 2'd3
    } wed_reg_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last_character;
    } wed_in_t;

    typedef struct packed {
        logic [4:0] distance;
        logic       within_limit;
        logic [4:0] candidate_length;
        logic       length_overflow;
    } wed_out_t;

    // One candidate character on its way down the chain.
    typedef struct packed {
        logic              valid;
        logic              upd;      // character updates the column
        logic              last;
        logic [CHAR_W-1:0] ch;
        logic [COST_W-1:0] left;     // new cost of the upstream cell
        logic [COST_W-1:0] diag;     // cost of the upstream cell before this character
        logic [COST_W-1:0] tap_cost; // cost picked up at the pattern-length tap
        logic [CNT_W-1:0]  count;
        logic              ovf;
    } wed_tok_t;

    function automatic logic [COST_W-1:0] sat_inc(input logic [COST_W-1:0] v);
        sat_inc = (v >= COST_CEILING) ? COST_CEILING : v + 1'b1;
    endfunction

    function automatic logic [COST_W-1:0] min3(input logic [COST_W-1:0] a,
                                               input logic [COST_W-1:0] b,
                                               input logic [COST_W-1:0] c);
        logic [COST_W-1:0] m;
        m    = (a < b) ? a : b;
        min3 = (m < c) ? m : c;
    endfunction

endpackage

// ===== rtl/core/wed_head.sv =====
// Head of the cell chain: candidate length counter, overflow flag and the
// cost of the empty pattern prefix. Launches one token per accepted character.
// Depends on wed_pkg.
module wed_head #(
    parameter int MAX_CANDIDATE_CHARS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  wed_pkg::wed_in_t  in_data,
    output wed_pkg::wed_tok_t tok
);

    logic [wed_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [wed_pkg::COST_W-1:0] cost_reg, cost_next;
    logic                       ovf_reg, ovf_next;
    wed_pkg::wed_tok_t          tok_reg, tok_next;
    logic                       full;
    logic                       take;

    assign full = count_reg >= wed_pkg::CNT_W'(MAX_CANDIDATE_CHARS);
    assign take = adv && in_valid;

    always_comb
    begin
        tok_next          = tok_reg;
        tok_next.valid    = in_valid;
        tok_next.upd      = !full;
        tok_next.last     = in_data.last_character;
        tok_next.ch       = in_data.character;
        tok_next.left     = wed_pkg::sat_inc(cost_reg);
        tok_next.diag     = cost_reg;
        tok_next.tap_cost = '0;
        tok_next.count    = full ? count_reg : count_reg + 1'b1;
        tok_next.ovf      = ovf_reg || full;
    end

    always_comb
    begin
        count_next = count_reg;
        cost_next  = cost_reg;
        ovf_next   = ovf_reg;
        if (take)
        begin
            if (in_data.last_character)
            begin
                // start over for the next candidate
                count_next = '0;
                cost_next  = '0;
                ovf_next   = 1'b0;
            end
            else if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
                cost_next  = wed_pkg::sat_inc(cost_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cost_reg  <= '0;
            ovf_reg   <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            cost_reg  <= cost_next;
            ovf_reg   <= ovf_next;
            if (adv)
            begin
                tok_reg <= tok_next;
            end
        end
    end

    assign tok = tok_reg;

endmodule

// ===== rtl/core/wed_cell.sv =====
// One pattern position of the DP column: holds its cost, updates it from the
// token of the upstream cell and hands the token on downstream.
// Depends on wed_pkg.
module wed_cell #(
    parameter int CELL_INDEX = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic [wed_pkg::CHAR_W-1:0]  pat_char,
    input  logic                        tap,
    input  wed_pkg::wed_tok_t           tin,
    output wed_pkg::wed_tok_t           tout
);

    localparam logic [wed_pkg::COST_W-1:0] COST_INIT = wed_pkg::COST_W'(CELL_INDEX);

    logic [wed_pkg::COST_W-1:0] cost_reg, cost_next;
    logic [wed_pkg::COST_W-1:0] sub_cost;
    logic [wed_pkg::COST_W-1:0] new_cost;
    wed_pkg::wed_tok_t          tok_reg, tok_next;
    logic                       same;

    assign same     = (pat_char == wed_pkg::WILDCARD) || (pat_char == tin.ch);
    assign sub_cost = same ? tin.diag : wed_pkg::sat_inc(tin.diag);
    assign new_cost = wed_pkg::min3(sub_cost, wed_pkg::sat_inc(cost_reg),
                                    wed_pkg::sat_inc(tin.left));

    always_comb
    begin
        tok_next      = tin;
        tok_next.left = new_cost;
        tok_next.diag = cost_reg;
        if (tap && tin.upd)
        begin
            tok_next.tap_cost = new_cost;
        end
    end

    always_comb
    begin
        cost_next = cost_reg;
        if (adv && tin.valid)
        begin
            if (tin.last)
            begin
                cost_next = COST_INIT;
            end
            else if (tin.upd)
            begin
                cost_next = new_cost;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cost_reg <= COST_INIT;
            tok_reg  <= '0;
        end
        else
        begin
            cost_reg <= cost_next;
            if (adv)
            begin
                tok_reg <= tok_next;
            end
        end
    end

    assign tout = tok_reg;

endmodule

// ===== rtl/core/wildcard_edit_distance.sv =====
// Wildcard edit distance: top level with configuration registers, the cell
// chain and the result register. Depends on wed_pkg, wed_head and wed_cell.
//
// Accepts one candidate character per cycle while in_ready is high. Each
// character walks down a chain of MAX_PATTERN_CHARS cells, one pattern position
// per cell and one cell per cycle while the chain advances, so characters of
// the same or of following candidates overlap in the chain. A candidate's result
// moves from the head register through each cell register to the result register.
// in_ready drops only while a result at the chain end waits for a full,
// untaken result register; no clearing pass is needed after reset.
module wildcard_edit_distance #(
    parameter int MAX_PATTERN_CHARS   = 16,
    parameter int MAX_CANDIDATE_CHARS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [wed_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wed_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  wed_pkg::wed_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output wed_pkg::wed_out_t               out_data
);

    localparam logic [wed_pkg::LEN_W-1:0] MAX_LEN = wed_pkg::LEN_W'(MAX_PATTERN_CHARS);
    localparam logic [wed_pkg::LEN_W-1:0] MIN_LEN = wed_pkg::LEN_W'(wed_pkg::MIN_PATTERN);

    logic [2*wed_pkg::CFG_W-1:0] pattern_reg;
    logic [wed_pkg::LEN_W-1:0]   pat_len_reg;
    logic [4:0]                  limit_reg;
    logic [wed_pkg::LEN_W-1:0]   eff_len;

    wed_pkg::wed_tok_t           chain [0:MAX_PATTERN_CHARS];
    wed_pkg::wed_tok_t           end_tok;
    logic                        end_result;
    logic                        adv;

    logic                        out_valid_reg, out_valid_next;
    wed_pkg::wed_out_t           out_reg, out_next;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            pat_len_reg <= MIN_LEN;
            limit_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                wed_pkg::REG_PAT_LO:     pattern_reg[wed_pkg::CFG_W-1:0] <= cfg_data;
                wed_pkg::REG_PAT_HI:     pattern_reg[2*wed_pkg::CFG_W-1:wed_pkg::CFG_W] <= cfg_data;
                wed_pkg::REG_PAT_LEN:    pat_len_reg <= cfg_data[wed_pkg::LEN_W-1:0];
                wed_pkg::REG_DIST_LIMIT: limit_reg <= cfg_data[4:0];
                default:                 ;
            endcase
        end
    end

    // Clamp pattern length into the supported range
    always_comb
    begin
        if (pat_len_reg < MIN_LEN)
        begin
            eff_len = MIN_LEN;
        end
        else if (pat_len_reg > MAX_LEN)
        begin
            eff_len = MAX_LEN;
        end
        else
        begin
            eff_len = pat_len_reg;
        end
    end

    assign end_tok    = chain[MAX_PATTERN_CHARS];
    assign end_result = end_tok.valid && end_tok.last;
    // Hold the whole chain only when a result cannot enter the output register
    assign adv        = !(end_result && out_valid_reg && !out_ready);
    assign in_ready   = adv;

    wed_head #(
        .MAX_CANDIDATE_CHARS (MAX_CANDIDATE_CHARS)
    ) u_head (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid),
        .in_data  (in_data),
        .tok      (chain[0])
    );

    for (genvar k = 1; k <= MAX_PATTERN_CHARS; k++)
    begin : g_cell
        wed_cell #(
            .CELL_INDEX (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .pat_char (pattern_reg[(k-1)*wed_pkg::CHAR_W +: wed_pkg::CHAR_W]),
            .tap      (eff_len == wed_pkg::LEN_W'(k)),
            .tin      (chain[k-1]),
            .tout     (chain[k])
        );
    end

    always_comb
    begin
        out_next.distance         = end_tok.ovf ? 5'd0 : end_tok.tap_cost;
        out_next.within_limit     = !end_tok.ovf && (end_tok.tap_cost <= limit_reg);
        out_next.candidate_length = end_tok.count[4:0];
        out_next.length_overflow  = end_tok.ovf;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv && end_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && end_result)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A result at the chain end never overwrites an untaken result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (end_result && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("result chain advanced into a full output register");

    // An overflowed candidate reports no distance and no match
    a_ovf_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.length_overflow) |->
            (!out_reg.within_limit && out_reg.distance == 5'd0))
        else $error("overflow result carries a distance or a match");

    // The candidate count never passes the maximum length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        chain[0].valid |-> (chain[0].count <= wed_pkg::CNT_W'(MAX_CANDIDATE_CHARS)))
        else $error("candidate count beyond maximum");

    // A character that skipped the column update belongs to an overflowed candidate
    a_skip_means_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (end_tok.valid && !end_tok.upd) |-> end_tok.ovf)
        else $error("column update skipped without overflow");

endmodule

// ===== test/wed_checker.sv =====
// Scoreboard for the wildcard edit distance block: mirrors the registers,
// keeps its own DP column and compares every result transaction in order.
// Depends on wed_pkg for the payload structs, register codes and wildcard.
module wed_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [wed_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wed_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  wed_pkg::wed_in_t              in_data,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  wed_pkg::wed_out_t             out_data,
    output int                            mismatches,
    output int                            results_pending
);

    localparam int CELLS    = 16;
    localparam int CAND_MAX = 16;

    logic [127:0]      pattern;
    logic [4:0]        pattern_len;
    logic [4:0]        dist_limit;
    logic [4:0]        column [0:CELLS];
    logic [4:0]        seen;
    logic              overflowed;
    wed_pkg::wed_out_t scores_due [$];
    wed_pkg::wed_out_t want;

    function automatic logic [4:0] plus_one(input logic [4:0] v);
        return (v == 5'd31) ? v : v + 5'd1;
    endfunction

    function automatic logic [4:0] least(input logic [4:0] a, input logic [4:0] b,
                                         input logic [4:0] c);
        logic [4:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    task automatic clear_column();
        for (int i = 0; i <= CELLS; i++)
            column[i] = 5'(i);
        seen = '0;
        overflowed = 1'b0;
    endtask

    // Advance the column by one candidate character; queue a score on the last one.
    task automatic score_character(input wed_pkg::wed_in_t item);
        logic [4:0]        diag;
        logic [4:0]        sub;
        logic [7:0]        pc;
        logic [4:0]        d;
        int                tap;
        wed_pkg::wed_out_t score;
        if (seen >= CAND_MAX)
            overflowed = 1'b1;
        else
        begin
            diag = column[0];
            column[0] = plus_one(column[0]);
            for (int i = 1; i <= CELLS; i++)
            begin
                pc = pattern[8*(i-1) +: 8];
                sub = (pc == wed_pkg::WILDCARD || pc == item.character) ? diag
                                                                       : plus_one(diag);
                diag = column[i];
                column[i] = least(sub, plus_one(column[i]), plus_one(column[i-1]));
            end
            seen = seen + 5'd1;
        end
        if (item.last_character)
        begin
            tap = (pattern_len < 3) ? 3 : (pattern_len > CELLS) ? CELLS : int'(pattern_len);
            d = column[tap];
            score.distance         = overflowed ? 5'd0 : d;
            score.within_limit     = !overflowed && (d <= dist_limit);
            score.candidate_length = seen;
            score.length_overflow  = overflowed;
            scores_due.insert(scores_due.size(), score);
            clear_column();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern = '0;
            pattern_len = 5'd3;
            dist_limit = '0;
            clear_column();
            scores_due.delete();
            results_pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (scores_due.size() == 0)
                begin
                    $error("unexpected result transaction: distance %0d length %0d",
                           out_data.distance, out_data.candidate_length);
                    mismatches++;
                end
                else
                begin
                    want = scores_due.pop_front();
                    if (out_data.distance !== want.distance)
                    begin
                        $error("distance: expected %0d, got %0d",
                               want.distance, out_data.distance);
                        mismatches++;
                    end
                    if (out_data.within_limit !== want.within_limit)
                    begin
                        $error("within_limit: expected %0d, got %0d",
                               want.within_limit, out_data.within_limit);
                        mismatches++;
                    end
                    if (out_data.candidate_length !== want.candidate_length)
                    begin
                        $error("candidate_length: expected %0d, got %0d",
                               want.candidate_length, out_data.candidate_length);
                        mismatches++;
                    end
                    if (out_data.length_overflow !== want.length_overflow)
                    begin
                        $error("length_overflow: expected %0d, got %0d",
                               want.length_overflow, out_data.length_overflow);
                        mismatches++;
                    end
                end
            end
            // The step sees the registers as they were before this edge.
            if (in_valid && in_ready)
                score_character(in_data);
            if (cfg_write)
            begin
                case (wed_pkg::wed_reg_t'(cfg_index))
                    wed_pkg::REG_PAT_LO:     pattern[63:0] = cfg_data;
                    wed_pkg::REG_PAT_HI:     pattern[127:64] = cfg_data;
                    wed_pkg::REG_PAT_LEN:    pattern_len = cfg_data[4:0];
                    wed_pkg::REG_DIST_LIMIT: dist_limit = cfg_data[4:0];
                    default: ;
                endcase
            end
            results_pending = scores_due.size();
        end
    end

endmodule

// ===== test/tb.sv =====
// Regression top for wildcard_edit_distance: clock, reset, register writes,
// candidate stimulus and the verdict. Depends on wed_pkg and wed_checker.
module tb;
    import wed_pkg::*;

    localparam int  RANDOM_ITEMS = 1150;
    localparam int  TAIL_CYCLES  = 24;
    localparam int  CAND_MAX     = 16;
    localparam time RUN_LIMIT    = 8000000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    wed_in_t              in_data;
    logic                 out_valid;
    logic                 out_ready;
    wed_out_t             out_data;
    int                   mismatches;
    int                   results_pending;

    logic                 calm;
    logic [127:0]         pat_bytes;
    int                   eff_len;
    int                   chars_sent;

    wildcard_edit_distance u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    wed_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .mismatches      (mismatches),
        .results_pending (results_pending)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
        out_ready <= calm || ($urandom_range(0, 99) >= 30);

    initial
    begin
        #(RUN_LIMIT);
        $display("wildcard_edit_distance regression: fail");
        $finish;
    end

    function automatic logic [7:0] alpha_char();
        case ($urandom_range(0, 4))
            0: return "A";
            1: return "B";
            2: return "C";
            3: return WILDCARD;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic write_reg(input wed_reg_t idx, input logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [127:0] pat, input logic [4:0] len,
                                 input logic [4:0] lim);
        write_reg(REG_PAT_LO, pat[63:0]);
        write_reg(REG_PAT_HI, pat[127:64]);
        write_reg(REG_PAT_LEN, CFG_W'(len));
        write_reg(REG_DIST_LIMIT, CFG_W'(lim));
        cfg_write <= 1'b0;
        pat_bytes = pat;
        eff_len = (len < 3) ? 3 : (len > 16) ? 16 : int'(len);
    endtask

    // Hold the transaction until in_ready is seen high ahead of a rising edge.
    task automatic send_char(input logic [7:0] ch, input logic last);
        logic took;
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 30)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= '{character: ch, last_character: last};
        do
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end
        while (!took);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    // Walk the pattern with random drops, insertions and substitutions, or send random bytes when noisy.
    task automatic send_candidate(input int n, input bit noisy);
        int         j;
        int         r;
        logic [7:0] ch;
        j = 0;
        for (int i = 0; i < n; i++)
        begin
            if (noisy)
                ch = 8'($urandom_range(0, 255));
            else
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    j++;
                if (r == 1 || j >= 16)
                    ch = alpha_char();
                else
                begin
                    ch = pat_bytes[8*j +: 8];
                    if (ch == WILDCARD || r == 2)
                        ch = alpha_char();
                    j++;
                end
            end
            send_char(ch, i == n - 1);
        end
    endtask

    // Drop valid, wait out every pending score, then let the chain empty.
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (results_pending != 0);
        @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [127:0] pat;
        logic [4:0]   len;
        logic [4:0]   lim;
        string        seed_text;
        int           phase;
        int           first_random;
        int           budget;
        int           phase_start;
        int           n;
        int           r;

        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        calm      = 1'b0;
        chars_sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: wildcard match, literal '?' in the candidate, byte extremes, overflow.
        seed_text = "W1?WX";
        pat = '0;
        for (int b = 0; b < seed_text.len(); b++)
            pat[8*b +: 8] = seed_text[b];
        load_settings(pat, 5'd5, 5'd1);
        send_text("W1ZWX");
        send_char(WILDCARD, 1'b1);
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b1);
        for (int i = 0; i <= CAND_MAX; i++)
            send_char(8'h41 + 8'(i), i == CAND_MAX);
        settle();

        first_random = chars_sent;
        phase = 0;
        while (chars_sent - first_random < RANDOM_ITEMS)
        begin
            if (phase == 0)
                pat = {16{WILDCARD}};
            else if (phase == 1)
                pat = '1;
            else if ($urandom_range(0, 3) == 0)
                pat = {$urandom, $urandom, $urandom, $urandom};
            else
                for (int b = 0; b < 16; b++)
                    pat[8*b +: 8] = alpha_char();
            case (phase)
                0: begin len = 5'd16; lim = 5'd0;  end
                1: begin len = 5'd3;  lim = 5'd16; end
                2: begin len = 5'd0;  lim = 5'd31; end
                3: begin len = 5'd31; lim = 5'd0;  end
                4: begin len = 5'd2;  lim = 5'd16; end
                5: begin len = 5'd17; lim = 5'd1;  end
                default:
                begin
                    len = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                      : 5'($urandom_range(3, 16));
                    lim = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                      : 5'($urandom_range(0, 6));
                end
            endcase
            load_settings(pat, len, lim);
            calm = (phase == 2);
            budget = $urandom_range(60, 120);
            phase_start = chars_sent;
            while (chars_sent - phase_start < budget)
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    n = $urandom_range(CAND_MAX + 1, CAND_MAX + 4);
                else if (r < 25)
                    n = $urandom_range(1, CAND_MAX);
                else
                begin
                    n = eff_len + $urandom_range(0, 4) - 2;
                    n = (n < 1) ? 1 : (n > CAND_MAX) ? CAND_MAX : n;
                end
                send_candidate(n, $urandom_range(0, 4) == 0);
            end
            settle();
            calm = 1'b0;
            phase++;
        end

        if (mismatches == 0)
            $display("wildcard_edit_distance regression: pass");
        else
            $display("wildcard_edit_distance regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/wed_pkg.sv
rtl/core/wed_head.sv
rtl/core/wed_cell.sv
rtl/core/wildcard_edit_distance.sv
test/wed_checker.sv
test/tb.sv
